// ===== rtl/nalsplit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsplit_pkg
// Shared constants, types and helpers of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package nalsplit_pkg;

	localparam int MAX_FRAME_BYTES = 1048576;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
	localparam int LEN_W           = POS_W + 1;
	localparam int TS_W            = 32;
	localparam int TYPE_W          = 5;

	localparam logic [LEN_W-1:0] RESET_BUDGET = LEN_W'(MAX_FRAME_BYTES);

	localparam logic [TYPE_W-1:0] NAL_SLICE = 5'h01;
	localparam logic [TYPE_W-1:0] NAL_IDR   = 5'h05;
	localparam logic [TYPE_W-1:0] NAL_SPS   = 5'h07;
	localparam logic [TYPE_W-1:0] NAL_PPS   = 5'h08;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 128;

	typedef struct packed {
		logic              emit;
		logic [POS_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic              seen;
		logic [TYPE_W-1:0] ntype;
		logic              last;
		logic [TS_W-1:0]   stamp;
	} unit_evt_t;

	function automatic logic wanted_type(input logic [TYPE_W-1:0] t);
		return (t == NAL_SLICE) || (t == NAL_IDR) || (t == NAL_SPS) || (t == NAL_PPS);
	endfunction

	function automatic logic is_slice(input logic [TYPE_W-1:0] t);
		return (t == NAL_SLICE) || (t == NAL_IDR);
	endfunction

endpackage

// ===== rtl/nalsplit_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsplit_scan
// Start code search and unit tracking; reports each closed unit as an event.
// ----------------------------------------------------------------------------
module nalsplit_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	input  logic [nalsplit_pkg::TS_W-1:0] frame_timestamp,
	output nalsplit_pkg::unit_evt_t    evt
);
	import nalsplit_pkg::*;

	logic [23:0]       recent_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  unit_start_q;
	logic [LEN_W-1:0]  search_lim_q;
	logic [TYPE_W-1:0] cur_type_q;
	logic              seen_q;
	logic              stopped_q;

	logic              last_eff;
	logic              capture;
	logic [TYPE_W-1:0] type_now;
	logic              seen_now;
	logic              stop_now;
	logic              split;
	logic [POS_W-1:0]  split_pos;

	always_comb begin
		last_eff  = last_byte || (pos_q == POS_W'(MAX_FRAME_BYTES - 1));
		capture   = !seen_q && (pos_q == unit_start_q + POS_W'(4));
		type_now  = capture ? data_byte[TYPE_W-1:0] : cur_type_q;
		seen_now  = seen_q || capture;
		stop_now  = stopped_q ||
			(capture && (unit_start_q != '0) && is_slice(data_byte[TYPE_W-1:0]));
		split     = !last_eff && !stop_now && (recent_q == '0) && (data_byte == 8'h01) &&
			({1'b0, pos_q} >= search_lim_q);
		split_pos = pos_q - POS_W'(3);

		evt.emit   = last_eff || split;
		evt.offset = unit_start_q;
		evt.length = last_eff ? ({1'b0, pos_q} + LEN_W'(1) - {1'b0, unit_start_q})
			: ({1'b0, split_pos} - {1'b0, unit_start_q});
		evt.seen   = seen_now;
		evt.ntype  = seen_now ? type_now : '0;
		evt.last   = last_eff;
		evt.stamp  = frame_timestamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			pos_q        <= '0;
			unit_start_q <= '0;
			search_lim_q <= LEN_W'(7);
			cur_type_q   <= '0;
			seen_q       <= 1'b0;
			stopped_q    <= 1'b0;
		end else if (step) begin
			if (last_eff) begin
				recent_q     <= '0;
				pos_q        <= '0;
				unit_start_q <= '0;
				search_lim_q <= LEN_W'(7);
				cur_type_q   <= '0;
				seen_q       <= 1'b0;
				stopped_q    <= 1'b0;
			end else begin
				recent_q  <= {recent_q[15:0], data_byte};
				pos_q     <= pos_q + POS_W'(1);
				stopped_q <= stop_now;
				if (split) begin
					unit_start_q <= split_pos;
					search_lim_q <= {1'b0, pos_q} + LEN_W'(4);
					cur_type_q   <= '0;
					seen_q       <= 1'b0;
				end else begin
					cur_type_q <= type_now;
					seen_q     <= seen_now;
				end
			end
		end
	end

endmodule

// ===== rtl/nalsplit_budget.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsplit_budget
// Copy budget accounting and the registered result transfer.
// ----------------------------------------------------------------------------
module nalsplit_budget (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [nalsplit_pkg::LEN_W-1:0]  cfg_wr_data,
	input  logic                            step,
	input  nalsplit_pkg::unit_evt_t         evt,
	output logic                            slot_free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nalsplit_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import nalsplit_pkg::*;

	logic [LEN_W-1:0] budget_q;
	logic [LEN_W-1:0] total_q;
	logic             sel;
	logic             fits;
	logic             cp;
	logic [LEN_W-1:0] total_next;
	logic [LEN_W:0]   sum;

	logic             out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic             out_last_q;

	always_comb begin
		sel        = evt.seen && wanted_type(evt.ntype);
		sum        = {1'b0, total_q} + {1'b0, evt.length};
		fits       = sum < {1'b0, budget_q};
		cp         = sel && fits;
		total_next = cp ? sum[LEN_W-1:0] : total_q;
		slot_free  = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= RESET_BUDGET;
		end else if (cfg_wr_en) begin
			budget_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step && evt.emit) begin
				out_valid_q <= 1'b1;
				total_q     <= evt.last ? '0 : total_next;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && evt.emit) begin
			out_data_q <= {6'b0, evt.stamp, total_next, total_q, cp, sel, evt.ntype,
				evt.length, evt.offset};
			out_last_q <= evt.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/h264_annexb_nal_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_annexb_nal_splitter
// Splits an Annex B byte stream into NAL units and reports each closed unit
// with its type, selection and copy budget status.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output register is free or taken.
// A closing byte is registered at the input, then its report at the output.
// Reset: arst_n clears the scan state and the running total and sets the
//   copy budget to 1048576; per-frame state also clears after each final byte.
// ----------------------------------------------------------------------------
module h264_annexb_nal_splitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [nalsplit_pkg::LEN_W-1:0]       cfg_wr_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [7:0] data_byte, [39:8] frame_timestamp
	input  logic [nalsplit_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [19:0] unit_offset, [40:20] unit_length, [45:41] unit_type, [46] selected,
	// [47] copied, [68:48] dest_offset, [89:69] total_copied,
	// [121:90] unit_timestamp, [127:122] zero
	output logic [nalsplit_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                                 m_tlast
);
	import nalsplit_pkg::*;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic [TS_W-1:0] ts_s1;
	logic            slot_free;
	logic            advance;
	unit_evt_t       evt;

	assign advance  = valid_s1 && slot_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			ts_s1   <= s_tdata[39:8];
			last_s1 <= s_tlast;
		end
	end

	nalsplit_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.data_byte       (byte_s1),
		.last_byte       (last_s1),
		.frame_timestamp (ts_s1),
		.evt             (evt)
	);

	nalsplit_budget u_budget (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.evt         (evt),
		.slot_free   (slot_free),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
